@@ src/ajb_pkg.sv @@
// ----------------------------------------------------------------------------
// ajb_pkg
// Shared constants, codes and types of the audio jitter buffer.
// ----------------------------------------------------------------------------
package ajb_pkg;

    // default geometry
    localparam int SLOTS_DEF   = 8;
    localparam int MAX_PKT_DEF = 256;
    localparam int POP_MAX_DEF = 64;

    // fixed field widths
    localparam int SEQ_W   = 16;
    localparam int SMP_W   = 16;
    localparam int CNT_W   = 7;
    localparam int ST_W    = 3;
    localparam int DEPTH_W = 4;

    // serial-number half range
    localparam logic [SEQ_W-1:0] HALF_RANGE = 16'h7fff;

    // input selector
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // result kind
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // push status codes
    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEN = 3'd1;
    localparam logic [ST_W-1:0] ST_STALE   = 3'd2;
    localparam logic [ST_W-1:0] ST_NO_ROOM = 3'd3;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd4;

    // configuration register indexes
    localparam logic CFG_START_DEPTH = 1'b0;
    localparam logic CFG_SILENCE     = 1'b1;

    // one result beat
    typedef struct packed {
        logic             kind;
        logic [ST_W-1:0]  status;
        logic [SMP_W-1:0] sample;
        logic             complete;
        logic             last;
    } t_beat;

    // request to the shared adder/subtractor
    typedef struct packed {
        logic [SEQ_W-1:0] a;
        logic [SEQ_W-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

@@ src/ajb_alu.sv @@
// ----------------------------------------------------------------------------
// ajb_alu
// Shared 16-bit add/subtract unit of the sequencer.
// ----------------------------------------------------------------------------
module ajb_alu import ajb_pkg::*; (
    input  t_alu_req         i_req,
    output logic [SEQ_W-1:0] o_y
);

    logic [SEQ_W-1:0] w_b;

    assign w_b = i_req.sub ? ~i_req.b : i_req.b;
    assign o_y = i_req.a + w_b + {{(SEQ_W-1){1'b0}}, i_req.sub};

endmodule

@@ src/ajb_mem.sv @@
// ----------------------------------------------------------------------------
// ajb_mem
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ajb_mem import ajb_pkg::*; #(
    parameter int DEPTH = SLOTS_DEF * MAX_PKT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [SMP_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [SMP_W-1:0] o_rd_data
);

    logic [SMP_W-1:0] r_mem [DEPTH];
    logic [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/ajb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ajb_ctrl
// Sequencer: slot table, sequence tracking, push close-out and playout.
// ----------------------------------------------------------------------------
module ajb_ctrl import ajb_pkg::*; #(
    parameter int SLOTS              = SLOTS_DEF,
    parameter int MAX_PACKET_SAMPLES = MAX_PKT_DEF,
    parameter int POP_MAX            = POP_MAX_DEF,
    parameter int AW                 = $clog2(SLOTS * MAX_PACKET_SAMPLES)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [SEQ_W-1:0]   i_seq,
    input  logic [SMP_W-1:0]   i_smp,
    input  logic               i_last,
    input  logic [CNT_W-1:0]   i_cnt,
    // configuration
    input  logic [DEPTH_W-1:0] i_start_depth,
    input  logic [SMP_W-1:0]   i_silence,
    // result beat
    output logic               o_emit_valid,
    output t_beat              o_emit,
    input  logic               i_emit_ready,
    // shared unit
    output t_alu_req           o_alu_req,
    input  logic [SEQ_W-1:0]   i_alu_y,
    // sample store
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [SMP_W-1:0]   o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    input  logic [SMP_W-1:0]   i_rd_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEN_W  = $clog2(MAX_PACKET_SAMPLES + 2);
    localparam int SCW    = $clog2(SLOTS + 1);
    localparam int PCW    = $clog2(POP_MAX + 1);
    localparam int CW     = ((SCW > DEPTH_W) ? SCW : DEPTH_W) + 1;
    // exact seq / SLOTS by reciprocal multiply for any 16-bit seq
    localparam int RSH    = SEQ_W + SLOT_W;
    localparam int RECIP  = (2 ** RSH) / SLOTS + 1;
    localparam int PW     = RSH + SEQ_W;

    localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_PACKET_SAMPLES);
    localparam logic [SEQ_W-1:0]  SLOTS_SEQ = SEQ_W'(SLOTS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);
    localparam logic [PCW-1:0]    POP_MAX_C = PCW'(POP_MAX);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD    = 4'd1;
    localparam logic [3:0] S_REM    = 4'd2;
    localparam logic [3:0] S_WR     = 4'd3;
    localparam logic [3:0] S_CL0    = 4'd4;
    localparam logic [3:0] S_CL1    = 4'd5;
    localparam logic [3:0] S_CL2    = 4'd6;
    localparam logic [3:0] S_STAT   = 4'd7;
    localparam logic [3:0] S_PSTART = 4'd8;
    localparam logic [3:0] S_PLOOK  = 4'd9;
    localparam logic [3:0] S_PEMIT  = 4'd10;

    logic [3:0]        r_state;

    // latched item
    logic [SEQ_W-1:0]  r_seq;
    logic [SMP_W-1:0]  r_smp;
    logic              r_last;
    logic [PCW-1:0]    r_left;

    // sequence state
    logic [SEQ_W-1:0]  r_exp;
    logic [SLOT_W-1:0] r_exp_slot;
    logic              r_known;
    logic              r_playing;
    logic [SCW-1:0]    r_stored;
    logic [LEN_W-1:0]  r_push_len;

    // slot table
    logic [SLOTS-1:0]  r_slot_valid;
    logic [SEQ_W-1:0]  r_slot_seq [SLOTS];
    logic [LEN_W-1:0]  r_slot_len [SLOTS];
    logic [LEN_W-1:0]  r_slot_off [SLOTS];

    // working registers
    logic [SEQ_W-1:0]  r_quot;
    logic [SLOT_W-1:0] r_slot;
    logic [LEN_W-1:0]  r_len;
    logic [ST_W-1:0]   r_status;
    logic              r_comp;
    logic              r_gap;
    logic              r_use_mem;

    logic              w_pop_side;
    logic [SLOT_W-1:0] w_idx;
    logic              w_valid_rd;
    logic [SEQ_W-1:0]  w_seq_rd;
    logic [LEN_W-1:0]  w_len_rd;
    logic [LEN_W-1:0]  w_off_rd;
    logic [LEN_W-1:0]  w_off_nxt;
    logic [LEN_W-1:0]  n_push_len;
    logic [PW-1:0]     w_prod;
    logic [SEQ_W-1:0]  w_qs;
    logic [PCW-1:0]    w_cnt_sat;
    logic [SLOT_W-1:0] w_exp_slot_nxt;
    logic              w_fin;
    logic              w_stored_low;

    // one table read port, pointed at the playout slot or the push slot
    assign w_pop_side = (r_state == S_PLOOK);
    assign w_idx      = w_pop_side ? r_exp_slot : r_slot;
    assign w_valid_rd = r_slot_valid[w_idx];
    assign w_seq_rd   = r_slot_seq[w_idx];
    assign w_len_rd   = r_slot_len[w_idx];
    assign w_off_rd   = r_slot_off[w_idx];
    assign w_off_nxt  = w_off_rd + LEN_W'(1);

    assign n_push_len = (r_push_len <= MAX_LEN) ? r_push_len + LEN_W'(1) : r_push_len;

    assign w_prod = PW'(r_seq) * PW'(RECIP);
    assign w_qs   = SEQ_W'(32'(r_quot) * 32'(SLOTS));

    assign w_cnt_sat = (i_cnt > CNT_W'(POP_MAX)) ? POP_MAX_C : PCW'(i_cnt);

    // sequence wrap to zero also restarts at slot zero
    assign w_exp_slot_nxt = ((r_exp == '1) || (r_exp_slot == SLOT_LAST)) ? '0
                            : r_exp_slot + SLOT_W'(1);

    assign w_fin        = (r_left == PCW'(1));
    assign w_stored_low = (CW'(r_stored) < CW'(i_start_depth));

    // shared unit operand selection
    always_comb begin
        o_alu_req = '{a: r_exp, b: SEQ_W'(1), sub: 1'b0};
        case (r_state)
            S_REM:   o_alu_req = '{a: r_seq, b: w_qs,  sub: 1'b1};
            S_CL1:   o_alu_req = '{a: r_seq, b: r_exp, sub: 1'b1};
            default: o_alu_req = '{a: r_exp, b: SEQ_W'(1), sub: 1'b0};
        endcase
    end

    // sample store ports
    assign o_wr_en   = (r_state == S_WR) && (r_push_len < MAX_LEN) && !w_valid_rd;
    assign o_wr_addr = AW'(32'(r_slot) * 32'(MAX_PACKET_SAMPLES) + 32'(r_push_len));
    assign o_wr_data = r_smp;
    assign o_rd_en   = w_pop_side && !r_gap && w_valid_rd && (w_seq_rd == r_exp)
                       && (w_off_rd < MAX_LEN);
    assign o_rd_addr = AW'(32'(r_exp_slot) * 32'(MAX_PACKET_SAMPLES) + 32'(w_off_rd));

    // result beat
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_emit_valid = (r_state == S_STAT) || (r_state == S_PEMIT);

    always_comb begin
        if (r_state == S_STAT) begin
            o_emit = '{kind: KIND_STATUS, status: r_status, sample: '0,
                       complete: 1'b0, last: 1'b1};
        end else begin
            o_emit = '{kind: KIND_SAMPLE, status: ST_OK,
                       sample: r_use_mem ? i_rd_data : i_silence,
                       complete: w_fin & r_comp, last: w_fin};
        end
    end

    // slot payload fields: no reset, read only behind a valid bit
    always_ff @(posedge i_clk) begin
        if (r_state == S_CL2 && !w_valid_rd) begin
            r_slot_seq[r_slot] <= r_seq;
            r_slot_len[r_slot] <= r_len;
            r_slot_off[r_slot] <= '0;
        end else if (o_rd_en || (w_pop_side && !r_gap && w_valid_rd
                                 && (w_seq_rd == r_exp))) begin
            r_slot_off[r_exp_slot] <= w_off_nxt;
        end
    end

    // item payload and working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_seq  <= i_seq;
                    r_smp  <= i_smp;
                    r_last <= i_last;
                end
            end
            S_MOD:  r_quot <= w_prod[RSH +: SEQ_W];
            S_REM:  r_slot <= i_alu_y[SLOT_W-1:0];
            S_WR: begin
                if (r_last) begin
                    r_len <= n_push_len;
                end
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_exp        <= '0;
            r_exp_slot   <= '0;
            r_known      <= 1'b0;
            r_playing    <= 1'b0;
            r_stored     <= '0;
            r_push_len   <= '0;
            r_slot_valid <= '0;
            r_left       <= '0;
            r_status     <= ST_OK;
            r_comp       <= 1'b0;
            r_gap        <= 1'b0;
            r_use_mem    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_left  <= w_cnt_sat;
                        r_state <= (i_func == FUNC_POP) ? S_PSTART : S_MOD;
                    end
                end
                S_MOD: r_state <= S_REM;
                S_REM: r_state <= S_WR;
                S_WR: begin
                    if (r_last) begin
                        r_push_len <= '0;
                        r_state    <= S_CL0;
                    end else begin
                        r_push_len <= n_push_len;
                        r_state    <= S_IDLE;
                    end
                end
                S_CL0: begin
                    if (r_len > MAX_LEN) begin
                        r_status <= ST_BAD_LEN;
                        r_state  <= S_STAT;
                    end else begin
                        if (!r_known) begin
                            r_exp      <= r_seq;
                            r_exp_slot <= r_slot;
                            r_known    <= 1'b1;
                        end
                        r_state <= S_CL1;
                    end
                end
                S_CL1: begin
                    // ALU holds seq - expected
                    if (i_alu_y > HALF_RANGE) begin
                        if (r_stored == '0 && !r_playing) begin
                            r_exp      <= r_seq;
                            r_exp_slot <= r_slot;
                            r_state    <= S_CL2;
                        end else begin
                            r_status <= ST_STALE;
                            r_state  <= S_STAT;
                        end
                    end else if (i_alu_y >= SLOTS_SEQ) begin
                        if (r_stored != '0) begin
                            r_status <= ST_NO_ROOM;
                            r_state  <= S_STAT;
                        end else begin
                            r_exp      <= r_seq;
                            r_exp_slot <= r_slot;
                            r_playing  <= 1'b0;
                            r_state    <= S_CL2;
                        end
                    end else begin
                        r_state <= S_CL2;
                    end
                end
                S_CL2: begin
                    if (w_valid_rd) begin
                        r_status <= (w_seq_rd == r_seq) ? ST_DUP : ST_NO_ROOM;
                    end else begin
                        r_slot_valid[r_slot] <= 1'b1;
                        r_stored             <= r_stored + SCW'(1);
                        r_status             <= ST_OK;
                    end
                    r_state <= S_STAT;
                end
                S_STAT: begin
                    if (i_emit_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_PSTART: begin
                    if (r_left == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_comp <= 1'b1;
                        r_gap  <= 1'b0;
                        if (!r_playing) begin
                            if (w_stored_low) begin
                                r_comp <= 1'b0;
                                r_gap  <= 1'b1;
                            end else begin
                                r_playing <= 1'b1;
                            end
                        end
                        r_state <= S_PLOOK;
                    end
                end
                S_PLOOK: begin
                    r_use_mem <= 1'b0;
                    if (!r_gap) begin
                        if (!w_valid_rd || w_seq_rd != r_exp) begin
                            // missing packet: skip it, silence for the rest
                            r_exp      <= i_alu_y;
                            r_exp_slot <= w_exp_slot_nxt;
                            if (r_stored == '0) begin
                                r_playing <= 1'b0;
                            end
                            r_comp <= 1'b0;
                            r_gap  <= 1'b1;
                        end else begin
                            r_use_mem <= (w_off_rd < MAX_LEN);
                            if (w_off_nxt >= w_len_rd) begin
                                r_slot_valid[r_exp_slot] <= 1'b0;
                                r_stored                 <= r_stored - SCW'(1);
                                r_exp                    <= i_alu_y;
                                r_exp_slot               <= w_exp_slot_nxt;
                            end
                        end
                    end
                    r_state <= S_PEMIT;
                end
                S_PEMIT: begin
                    if (i_emit_ready) begin
                        if (w_fin) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_left  <= r_left - PCW'(1);
                            r_state <= S_PLOOK;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/audio_jitter_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// audio_jitter_buffer_unit
// Reordering jitter buffer for sequence-numbered 16-bit audio packets.
// ----------------------------------------------------------------------------
// Packets land in SLOTS slots (slot = sequence mod SLOTS) and play out in
// sequence order. Push beats carry one sample each; the tlast beat closes
// the packet and returns one status beat (ok, bad length, stale, no room,
// duplicate). A pop beat asks for pop_count samples (saturated to POP_MAX)
// and returns that many sample beats, the last one flagged with tlast and
// with complete set if no silence was inserted. Playout waits until
// start_depth packets are held; a missing packet ends real data for the
// request and the expected sequence skips one. Everything runs through one
// sequencer and a shared 16-bit adder, so one item is in flight at a time.
// A final push beat also runs the close-out steps (fewer when the packet is
// overlong) plus any wait on the output, and a pop steps through a
// look-up/emit pair per sample around the registered read of the sample
// store. A zero pop returns nothing. Results sit in an output register so
// a new item can be taken while the last beat waits. Config writes are
// always accepted and are meant for idle periods only. No clearing pass.
// ----------------------------------------------------------------------------
module audio_jitter_buffer_unit import ajb_pkg::*; #(
    parameter int SLOTS              = SLOTS_DEF,
    parameter int MAX_PACKET_SAMPLES = MAX_PKT_DEF,
    parameter int POP_MAX            = POP_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // seq_number[15:0], sample_in[31:16],
                                        // pop_count[38:32], zero[39]
    input  logic        s_axis_tlast,   // last_in
    input  logic        s_axis_tuser,   // func
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // push_status[2:0], sample_out[18:3],
                                        // complete[19], zero[23:20]
    output logic        m_axis_tlast,   // last_out
    output logic        m_axis_tuser,   // kind
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(SLOTS * MAX_PACKET_SAMPLES);

    logic [DEPTH_W-1:0] r_start_depth;
    logic [SMP_W-1:0]   r_silence;

    logic               r_out_valid;
    t_beat              r_out;

    logic               w_emit_valid;
    t_beat              w_emit;
    logic               w_out_free;

    t_alu_req           w_alu_req;
    logic [SEQ_W-1:0]   w_alu_y;

    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [SMP_W-1:0]   w_wr_data;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic [SMP_W-1:0]   w_rd_data;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_depth <= DEPTH_W'(2);
            r_silence     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_DEPTH: r_start_depth <= i_cfg_data[DEPTH_W-1:0];
                CFG_SILENCE:     r_silence     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register: loads whenever empty or being drained
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit_valid) begin
            r_out <= w_emit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.complete, r_out.sample, r_out.status};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.kind;

    ajb_ctrl #(
        .SLOTS              (SLOTS),
        .MAX_PACKET_SAMPLES (MAX_PACKET_SAMPLES),
        .POP_MAX            (POP_MAX),
        .AW                 (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_func        (s_axis_tuser),
        .i_seq         (s_axis_tdata[15:0]),
        .i_smp         (s_axis_tdata[31:16]),
        .i_last        (s_axis_tlast),
        .i_cnt         (s_axis_tdata[38:32]),
        .i_start_depth (r_start_depth),
        .i_silence     (r_silence),
        .o_emit_valid  (w_emit_valid),
        .o_emit        (w_emit),
        .i_emit_ready  (w_out_free),
        .o_alu_req     (w_alu_req),
        .i_alu_y       (w_alu_y),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data)
    );

    ajb_alu u_alu (
        .i_req (w_alu_req),
        .o_y   (w_alu_y)
    );

    ajb_mem #(
        .DEPTH (SLOTS * MAX_PACKET_SAMPLES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

endmodule

@@ src/ajb_checker.sv @@
// ----------------------------------------------------------------------------
// ajb_checker
// Port-level checks on the jitter buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ajb_checker import ajb_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic        m_axis_tuser
);

    // every accepted item makes the sequencer busy, so input ready drops
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an accepted beat");

    // a status beat is always the only, hence last, result of its push
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tlast)
        else $error("status beat without tlast");

    // status code within the defined set
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_STATUS |-> m_axis_tdata[2:0] <= ST_DUP)
        else $error("undefined push status");

    // complete only flagged on the final sample of a pop
    a_complete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[19])
        else $error("complete set before the final sample");

    // result valid holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

endmodule

bind audio_jitter_buffer_unit ajb_checker u_ajb_checker (.*);

@@ dv/tb_audio_jitter_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// tb_audio_jitter_buffer_unit
// Self-checking bench for the audio jitter buffer.
// ----------------------------------------------------------------------------
// Items go in through a queue-fed driver and results come back through a
// monitor that sees every accepted beat on both streams. A behavioural copy
// of the buffer (slots, sample memory, expected sequence, playout state) is
// stepped on each accepted input beat and on each register write, and the
// result beats it predicts are held in order and compared field by field.
// A directed opener walks the ok, duplicate, stale and no-room statuses,
// resync, gap fill, zero and oversized pops and the sequence wrap; random
// phases under several register settings follow, with random back-pressure
// and hold-offs on both streams.
// ----------------------------------------------------------------------------
module tb_audio_jitter_buffer_unit;
    import ajb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles allowed after the last result before calling the block idle
    localparam int SETTLE_CYCLES = 20;

    // one input beat as the stimulus sees it
    typedef struct packed {
        logic             func;
        logic [SEQ_W-1:0] seq;
        logic [SMP_W-1:0] smp;
        logic             fin;
        logic [CNT_W-1:0] cnt;
    } t_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // seq_number[15:0], sample_in[31:16],
                                      // pop_count[38:32], zero[39]
    logic        s_axis_tlast = 1'b0; // last_in
    logic        s_axis_tuser = 1'b0; // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // push_status[2:0], sample_out[18:3],
                                      // complete[19], zero[23:20]
    logic        m_axis_tlast;        // last_out
    logic        m_axis_tuser;        // kind
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_START_DEPTH;
    logic [15:0] i_cfg_data = '0;

    audio_jitter_buffer_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Buffer shadow: slots, sample memory and playout state
    // ------------------------------------------------------------------
    logic [DEPTH_W-1:0] cfg_depth   = 4'd2;
    logic [SMP_W-1:0]   cfg_silence = '0;

    bit               slot_full [SLOTS_DEF];
    logic [SEQ_W-1:0] slot_seq  [SLOTS_DEF];
    int               slot_len  [SLOTS_DEF];
    int               slot_rd   [SLOTS_DEF];
    logic [SMP_W-1:0] sample_mem [SLOTS_DEF*MAX_PKT_DEF];
    logic [SEQ_W-1:0] next_seq  = '0;
    bit               seq_known = 1'b0;
    bit               is_playing = 1'b0;
    int               held_pkts = 0;
    int               rx_len    = 0;

    t_beat due_beats [$];   // results still owed by the block, oldest first
    t_req  tx_items  [$];   // beats waiting for the driver

    // bookkeeping for the closing summary
    int st_seen [5];
    int pops_taken   = 0;
    int beats_checked = 0;
    int fault_count  = 0;

    int         issued  = 0;
    logic [15:0] gen_seq = '0;
    bit         idle_on = 1'b1;
    int         tx_gap  = 0;
    int         rx_stall = 0;
    logic       in_fire = 1'b0;

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // serial-number order: a comes before b
    function automatic bit seq_before(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d > HALF_RANGE;
    endfunction

    // status of a packet whose closing beat just arrived
    function automatic logic [ST_W-1:0] close_packet(logic [SEQ_W-1:0] seq, int len);
        int sl;
        logic [SEQ_W-1:0] ahead;
        if (len > MAX_PKT_DEF)
            return ST_BAD_LEN;
        if (!seq_known) begin
            next_seq  = seq;
            seq_known = 1'b1;
        end
        if (seq_before(seq, next_seq)) begin
            // late packet resyncs only an empty, stopped buffer
            if (held_pkts == 0 && !is_playing)
                next_seq = seq;
            else
                return ST_STALE;
        end
        ahead = seq - next_seq;
        if (ahead >= SLOTS_DEF) begin
            if (held_pkts != 0)
                return ST_NO_ROOM;
            next_seq   = seq;
            is_playing = 1'b0;
        end
        sl = int'(seq) % SLOTS_DEF;
        if (slot_full[sl])
            return (slot_seq[sl] == seq) ? ST_DUP : ST_NO_ROOM;
        slot_seq[sl]  = seq;
        slot_len[sl]  = len;
        slot_rd[sl]   = 0;
        slot_full[sl] = 1'b1;
        held_pkts++;
        return ST_OK;
    endfunction

    function automatic void jb_push(logic [SEQ_W-1:0] seq, logic [SMP_W-1:0] smp,
                                    logic fin);
        int sl;
        int len;
        logic [ST_W-1:0] st;
        sl = int'(seq) % SLOTS_DEF;
        if (rx_len < MAX_PKT_DEF && !slot_full[sl])
            sample_mem[sl*MAX_PKT_DEF + rx_len] = smp;
        if (rx_len <= MAX_PKT_DEF)
            rx_len++;
        if (!fin)
            return;
        len    = rx_len;
        rx_len = 0;
        st     = close_packet(seq, len);
        st_seen[st]++;
        due_beats.push_back('{kind: KIND_STATUS, status: st, sample: '0,
                              complete: 1'b0, last: 1'b1});
    endfunction

    function automatic void jb_pop(logic [CNT_W-1:0] req);
        int n;
        int sl;
        int off;
        bit comp;
        bit gap;
        bit fin;
        logic [SMP_W-1:0] v;
        n = int'(req);
        if (n == 0)
            return;
        if (n > POP_MAX_DEF)
            n = POP_MAX_DEF;
        pops_taken++;
        comp = 1'b1;
        gap  = 1'b0;
        if (!is_playing) begin
            if (held_pkts < int'(cfg_depth)) begin
                comp = 1'b0;
                gap  = 1'b1;
            end else begin
                is_playing = 1'b1;
            end
        end
        for (int i = 0; i < n; i++) begin
            v   = cfg_silence;
            fin = (i == n - 1);
            if (!gap) begin
                sl = int'(next_seq) % SLOTS_DEF;
                if (!slot_full[sl] || slot_seq[sl] != next_seq) begin
                    // missing packet: skip it and fill the rest with silence
                    next_seq++;
                    if (held_pkts == 0)
                        is_playing = 1'b0;
                    comp = 1'b0;
                    gap  = 1'b1;
                end else begin
                    off = slot_rd[sl];
                    if (off < MAX_PKT_DEF)
                        v = sample_mem[sl*MAX_PKT_DEF + off];
                    off++;
                    slot_rd[sl] = off;
                    if (off >= slot_len[sl]) begin
                        slot_full[sl] = 1'b0;
                        held_pkts--;
                        next_seq++;
                    end
                end
            end
            due_beats.push_back('{kind: KIND_SAMPLE, status: ST_OK, sample: v,
                                  complete: fin & comp, last: fin});
        end
    endfunction

    // ------------------------------------------------------------------
    // Random gap lengths: mostly none, some short, a few long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // input driver: next beat from the queue once the current one is taken
    always @(negedge i_clk) begin : drive_in
        t_req nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (tx_gap != 0) begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (tx_items.size() != 0) begin
                nxt = tx_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, nxt.cnt, nxt.smp, nxt.seq};
                s_axis_tlast  <= nxt.fin;
                s_axis_tuser  <= nxt.func;
                tx_gap        <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_stall != 0) begin
            rx_stall      <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall      <= pick_gap();
        end
    end

    // monitor: steps the shadow on accepted beats and checks every result beat
    always @(posedge i_clk) begin : watch
        t_beat got;
        t_beat want;
        in_fire <= s_axis_tvalid && s_axis_tready && i_rst_n;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_START_DEPTH)
                    cfg_depth = i_cfg_data[DEPTH_W-1:0];
                else
                    cfg_silence = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == FUNC_PUSH)
                    jb_push(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
                else
                    jb_pop(s_axis_tdata[38:32]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{kind: m_axis_tuser, status: m_axis_tdata[2:0],
                        sample: m_axis_tdata[18:3], complete: m_axis_tdata[19],
                        last: m_axis_tlast};
                if (due_beats.size() == 0) begin
                    note_fault($sformatf("result beat with none expected: kind=%0d st=%0d smp=%h",
                                         got.kind, got.status, got.sample));
                end else begin
                    want = due_beats.pop_front();
                    beats_checked++;
                    if (got !== want)
                        note_fault($sformatf({"mismatch: expected kind=%0d st=%0d smp=%h ",
                                              "cmp=%0d last=%0d, got kind=%0d st=%0d ",
                                              "smp=%h cmp=%0d last=%0d"},
                                             want.kind, want.status, want.sample,
                                             want.complete, want.last, got.kind,
                                             got.status, got.sample, got.complete,
                                             got.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(logic func, logic [SEQ_W-1:0] seq, logic fin,
                              logic [CNT_W-1:0] cnt);
        t_req r;
        r.func = func;
        r.seq  = seq;
        r.smp  = SMP_W'($urandom);
        r.fin  = fin;
        r.cnt  = cnt;
        tx_items.push_back(r);
        issued++;
    endtask

    task automatic send_packet(logic [SEQ_W-1:0] seq, int len);
        for (int i = 0; i < len; i++)
            queue_beat(FUNC_PUSH, seq, i == len - 1, CNT_W'($urandom));
    endtask

    task automatic send_pop(int cnt);
        queue_beat(FUNC_POP, SEQ_W'($urandom), 1'($urandom_range(0, 1)), CNT_W'(cnt));
    endtask

    function automatic int pkt_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(1, 6);
        return $urandom_range(7, 20);
    endfunction

    function automatic int pop_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return 0;
        if (r < 10)
            return $urandom_range(POP_MAX_DEF + 1, 127);
        if (r < 15)
            return POP_MAX_DEF;
        if (r < 30)
            return $urandom_range(17, POP_MAX_DEF - 1);
        return $urandom_range(1, 16);
    endfunction

    // hold the sender until every owed result is in and the block has settled
    task automatic drain();
        while (tx_items.size() != 0 || s_axis_tvalid || due_beats.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // a run of consecutive packets, shuffled with some lost and some repeated,
    // mostly followed by pops that play them out
    task automatic packet_window();
        logic [SEQ_W-1:0] seqs [$];
        logic [SEQ_W-1:0] t;
        int k;
        int j;
        int len;
        int owed;
        int take;
        k    = $urandom_range(1, 6);
        owed = 0;
        for (int i = 0; i < k; i++) begin
            if ($urandom_range(0, 11) != 0)
                seqs.push_back(gen_seq + i[15:0]);
            else
                owed++;         // a lost packet costs one silent beat
        end
        for (int i = seqs.size() - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = seqs[i];
            seqs[i] = seqs[j];
            seqs[j] = t;
        end
        foreach (seqs[i]) begin
            len   = pkt_len();
            owed += len;
            send_packet(seqs[i], len);
            if ($urandom_range(0, 9) == 0)
                send_packet(seqs[i], pkt_len());
        end
        gen_seq += k[15:0];
        if ($urandom_range(0, 4) != 0) begin
            while (owed > 0) begin
                take = $urandom_range(1, POP_MAX_DEF);
                if (take > owed)
                    take = owed;
                send_pop(take);
                owed -= take;
            end
        end
    endtask

    task automatic random_phase(int n);
        int stop;
        int r;
        stop = issued + n;
        while (issued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                packet_window();
            end else if (r < 78) begin
                send_pop(pop_size());
            end else if (r < 86) begin
                send_packet(gen_seq - 16'($urandom_range(1, 40)), pkt_len());
            end else if (r < 92) begin
                send_packet(gen_seq + 16'($urandom_range(8, 40)), pkt_len());
            end else if (r < 96) begin
                gen_seq = SEQ_W'($urandom);
                send_packet(gen_seq, pkt_len());
                gen_seq++;
            end else begin
                drain();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_START_DEPTH, 16'd2);
        write_reg(CFG_SILENCE, 16'hffff);

        // directed opener
        send_pop(1);                     // nothing held: silence
        send_packet(16'd100, 1);         // first packet sets the sequence
        send_packet(16'd100, 2);         // duplicate
        send_packet(16'd99, 1);          // stale
        send_packet(16'd108, 1);         // beyond the window: no room
        send_packet(16'd101, 3);
        // sequence moves inside a packet; the closing one is a duplicate
        queue_beat(FUNC_PUSH, 16'd103, 1'b0, 7'd0);
        queue_beat(FUNC_PUSH, 16'd103, 1'b0, 7'd0);
        queue_beat(FUNC_PUSH, 16'd101, 1'b1, 7'd0);
        send_pop(0);                     // no result at all
        send_pop(127);                   // saturates, runs into a gap
        send_pop(1);
        send_packet(16'd50, 1);          // late but buffer empty: resync
        send_packet(16'd51, 2);
        send_pop(3);                     // fully real data
        send_pop(1);                     // gap
        send_packet(16'd52, 20);         // longer packet, read across a pop
        send_packet(16'd53, 1);
        send_pop(POP_MAX_DEF);
        send_pop(1);
        send_packet(16'hffff, 1);        // wrap of the sequence space
        send_packet(16'h0000, 1);
        send_pop(2);
        drain();

        // start immediately, zero silence
        write_reg(CFG_START_DEPTH, 16'd0);
        write_reg(CFG_SILENCE, 16'h0000);
        gen_seq = 16'hfffc;
        random_phase(30);
        drain();

        // deepest legal start depth, no idling on either side
        write_reg(CFG_START_DEPTH, 16'd8);
        write_reg(CFG_SILENCE, 16'($urandom));
        idle_on = 1'b0;
        random_phase(30);
        drain();
        idle_on = 1'b1;

        // depth out of reach: playout never starts
        write_reg(CFG_START_DEPTH, 16'd15);
        random_phase(15);
        drain();

        write_reg(CFG_START_DEPTH, 16'($urandom_range(1, 4)));
        write_reg(CFG_SILENCE, 16'($urandom));
        random_phase(25);
        drain();
        random_phase(25);
        drain();

        if (due_beats.size() != 0)
            note_fault($sformatf("%0d result beats never arrived", due_beats.size()));
        $display("covered %0d input beats, %0d packets closed",
                 issued, st_seen[0] + st_seen[1] + st_seen[2] + st_seen[3] + st_seen[4]);
        $display("  ok %0d, bad length %0d, stale %0d, no room %0d, dup %0d",
                 st_seen[ST_OK], st_seen[ST_BAD_LEN], st_seen[ST_STALE],
                 st_seen[ST_NO_ROOM], st_seen[ST_DUP]);
        $display("%0d pop requests, %0d result beats checked, %0d faults",
                 pops_taken, beats_checked, fault_count);
        if (fault_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
